// ===== design/mmde_pkg.sv =====
// package for the matrix multiply dot engine
// holds field widths, request codes and the pipeline tag type; no dependencies

package mmde_pkg;

   // field widths of the request and response channels
   localparam int REQ_W      = 2;
   localparam int COORD_W    = 4;
   localparam int VALUE_W    = 16;
   localparam int PRODUCT_W  = 36;
   localparam int SIZE_W     = 5;
   localparam int ELEM_PROD_W = 2 * VALUE_W;

   // matrix size after reset
   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

   // request codes
   localparam logic [REQ_W-1:0] REQ_WRITE_A = 2'd0;
   localparam logic [REQ_W-1:0] REQ_WRITE_B = 2'd1;
   localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

   // control tag that travels with each multiply-accumulate step
   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } mmde_tag_type;

endpackage

// ===== design/mmde_store.sv =====
// element store: one write port, one read port with registered read data
// depends on nothing; used twice by the top level for the two matrices

module mmde_store #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, read data registered when enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mmde_mac.sv =====
// multiply-accumulate unit: registered 16x16 product, then 36-bit accumulator
// depends on mmde_pkg for widths and the step tag

module mmde_mac
   import mmde_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  mmde_tag_type                tag,
   input  logic signed [VALUE_W-1:0]   a_val,
   input  logic signed [VALUE_W-1:0]   b_val,
   output logic                        done,
   output logic signed [PRODUCT_W-1:0] acc
);

   logic signed [ELEM_PROD_W-1:0] prod_ff;
   logic signed [ELEM_PROD_W-1:0] prod_in;
   mmde_tag_type                  ptag_ff;
   logic signed [PRODUCT_W-1:0]   acc_ff;
   logic signed [PRODUCT_W-1:0]   acc_in;
   logic signed [PRODUCT_W-1:0]   prod_ext;
   logic                          done_ff;

   // multiply stage
   assign prod_in = a_val * b_val;

   always_ff @(posedge clock) begin
      if (tag.vld) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptag_ff <= '0;
      end else begin
         ptag_ff <= tag;
      end
   end

   // accumulate stage, restarts on the first step of a dot product
   assign prod_ext = {{(PRODUCT_W - ELEM_PROD_W){prod_ff[ELEM_PROD_W-1]}}, prod_ff};
   assign acc_in   = (ptag_ff.first ? '0 : acc_ff) + prod_ext;

   always_ff @(posedge clock) begin
      if (ptag_ff.vld) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= ptag_ff.vld & ptag_ff.last;
      end
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

// ===== design/matrix_multiply_dot_engine.sv =====
// matrix multiply dot engine: element stores for A and B and a dot product sequencer
// depends on mmde_pkg, mmde_store and mmde_mac
//
// usage:
//   request channel: a transfer happens at a clock edge with start high and busy low.
//     req_type selects write A element, write B element or read product element C(row,col).
//   response channel: rsp_strobe is high for one cycle with the product, the echoed
//     coordinates and the out-of-range flag; the receiver cannot stall it.
//   csr port: csr_wr_en writes the matrix size; write it only while no request is in flight (not enforced).
// timing:
//   a write gives no response; busy stays low.
//   an out-of-range read answers on the cycle after its transfer and keeps busy low.
//   an in-range read over size n holds busy through the issue and drain states, so
//   no new request is taken until its product is done; the single multiply-accumulate
//   unit walks one row of A and one column of B, one element pair per cycle from the
//   two store read ports, and the response comes in the cycle busy drops.
//   writes and reads never overlap, so the stores need no forwarding.
// reset: synchronous, sets the matrix size to 16 and idles the sequencer; store
//   contents are not cleared and must be written before they are read.

module matrix_multiply_dot_engine
   import mmde_pkg::*;
#(
   parameter int MAX_DIM = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [REQ_W-1:0]            req_type,
   input  logic [COORD_W-1:0]          req_row,
   input  logic [COORD_W-1:0]          req_col,
   input  logic signed [VALUE_W-1:0]   req_value,
   output logic                        rsp_strobe,
   output logic signed [PRODUCT_W-1:0] rsp_product,
   output logic [COORD_W-1:0]          rsp_out_row,
   output logic [COORD_W-1:0]          rsp_out_col,
   output logic                        rsp_out_of_range,
   input  logic                        csr_wr_en,
   input  logic [SIZE_W-1:0]           csr_wr_data
);

   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int N_W    = $clog2(MAX_DIM + 1);
   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ISSUE = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [SIZE_W-1:0]           size_ff;
   logic [N_W-1:0]              size_use;
   logic                        accept;
   logic                        outside;
   logic                        is_write;
   logic [COORD_W-1:0]          row_ff, col_ff;
   logic [IDX_W-1:0]            k_ff, k_in;
   logic                        k_last;
   logic [IDX_W-1:0]            req_row_idx, req_col_idx, row_idx, col_idx;
   logic [ADDR_W-1:0]           wr_addr, rd_addr_a, rd_addr_b;
   logic                        wr_a, wr_b;
   logic                        issue;
   mmde_tag_type                tag_ff, tag_in;
   logic [VALUE_W-1:0]          rd_a, rd_b;
   logic                        mac_done;
   logic signed [PRODUCT_W-1:0] mac_acc;
   logic                        rsp_strobe_ff;
   logic signed [PRODUCT_W-1:0] rsp_product_ff;
   logic [COORD_W-1:0]          rsp_row_ff, rsp_col_ff;
   logic                        rsp_oor_ff;

   // size register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   // size in use saturates at the store dimension
   assign size_use = (32'(size_ff) > MAX_DIM) ? N_W'(MAX_DIM) : N_W'(size_ff);

   // request decode
   assign accept   = start & (state_ff == S_IDLE);
   assign outside  = (32'(req_row) >= 32'(size_use)) || (32'(req_col) >= 32'(size_use));
   assign is_write = (req_type == REQ_WRITE_A) || (req_type == REQ_WRITE_B);

   assign req_row_idx = IDX_W'(req_row);
   assign req_col_idx = IDX_W'(req_col);
   assign wr_addr     = ADDR_W'(32'(req_row_idx) * MAX_DIM + 32'(req_col_idx));
   assign wr_a        = accept & !outside & (req_type == REQ_WRITE_A);
   assign wr_b        = accept & !outside & (req_type == REQ_WRITE_B);

   // sequencer
   assign k_last = (32'(k_ff) + 32'd1) == 32'(size_use);
   assign issue  = (state_ff == S_ISSUE);

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      case (state_ff)
         S_IDLE: begin
            k_in = '0;
            if (accept && (req_type == REQ_READ) && !outside) begin
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            k_in = k_ff + 1'b1;
            if (k_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (mac_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   // coordinates of the request in flight
   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff <= req_row;
         col_ff <= req_col;
      end
   end

   // read addresses walk row of A and column of B
   assign row_idx   = IDX_W'(row_ff);
   assign col_idx   = IDX_W'(col_ff);
   assign rd_addr_a = ADDR_W'(32'(row_idx) * MAX_DIM + 32'(k_ff));
   assign rd_addr_b = ADDR_W'(32'(k_ff) * MAX_DIM + 32'(col_idx));

   // step tag lines up with the store read data
   assign tag_in.vld   = issue;
   assign tag_in.first = issue & (k_ff == '0);
   assign tag_in.last  = issue & k_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   mmde_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (VALUE_W)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (issue),
      .rd_addr (rd_addr_a),
      .rd_data (rd_a)
   );

   mmde_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (VALUE_W)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (issue),
      .rd_addr (rd_addr_b),
      .rd_data (rd_b)
   );

   mmde_mac u_mac (
      .clock (clock),
      .reset (reset),
      .tag   (tag_ff),
      .a_val (signed'(rd_a)),
      .b_val (signed'(rd_b)),
      .done  (mac_done),
      .acc   (mac_acc)
   );

   // response register: out-of-range reads answer at once, others when the sum is done
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (accept & (req_type == REQ_READ) & outside)
                          | ((state_ff == S_DRAIN) & mac_done);
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_type == REQ_READ) && outside) begin
         rsp_product_ff <= '0;
         rsp_row_ff     <= req_row;
         rsp_col_ff     <= req_col;
         rsp_oor_ff     <= 1'b1;
      end else if ((state_ff == S_DRAIN) && mac_done) begin
         rsp_product_ff <= mac_acc;
         rsp_row_ff     <= row_ff;
         rsp_col_ff     <= col_ff;
         rsp_oor_ff     <= 1'b0;
      end
   end

   assign busy             = (state_ff != S_IDLE) && !is_write ? 1'b1 : (state_ff != S_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_product      = rsp_product_ff;
   assign rsp_out_row      = rsp_row_ff;
   assign rsp_out_col      = rsp_col_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

// ===== tb/tb_top.sv =====
// testbench for the matrix multiply dot engine: element writes, product reads, size changes
// depends on mmde_pkg and matrix_multiply_dot_engine
// self-checking against its own dot product predictor
`timescale 1ns / 1ps

module tb_top;
   import mmde_pkg::*;

   localparam int DIM = 16;
   localparam int DRAIN_CYCLES = DIM + 8;
   localparam int LIMIT_CYCLES = 600000;
   localparam int ITEMS_PER_PHASE = 150;
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 16'sh8000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 16'sh7fff;

   typedef struct {
      logic [REQ_W-1:0]          kind;
      logic [COORD_W-1:0]        row;
      logic [COORD_W-1:0]        col;
      logic signed [VALUE_W-1:0] value;
   } mm_request_type;

   typedef struct {
      logic signed [PRODUCT_W-1:0] product;
      logic [COORD_W-1:0]          row;
      logic [COORD_W-1:0]          col;
      logic                        oor;
   } dot_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [REQ_W-1:0]            req_type = REQ_WRITE_A;
   logic [COORD_W-1:0]          req_row = '0;
   logic [COORD_W-1:0]          req_col = '0;
   logic signed [VALUE_W-1:0]   req_value = '0;
   logic                        rsp_strobe;
   logic signed [PRODUCT_W-1:0] rsp_product;
   logic [COORD_W-1:0]          rsp_out_row;
   logic [COORD_W-1:0]          rsp_out_col;
   logic                        rsp_out_of_range;
   logic                        csr_wr_en = 1'b0;
   logic [SIZE_W-1:0]           csr_wr_data = '0;

   // stimulus and prediction state
   mm_request_type            pending_reqs[$];
   dot_result_type            expected_products[$];
   logic signed [VALUE_W-1:0] a_elems [DIM*DIM];
   logic signed [VALUE_W-1:0] b_elems [DIM*DIM];
   bit                        a_written [DIM*DIM];
   bit                        b_written [DIM*DIM];
   logic [SIZE_W-1:0]         size_now = SIZE_RESET;
   int                        phase_count = 0;
   int                        mismatches = 0;
   int                        cycle_count = 0;

   matrix_multiply_dot_engine #(.MAX_DIM(DIM)) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_product      (rsp_product),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #4 clock = ~clock;

   // sizes above the store dimension saturate
   function automatic int dim_in_use(logic [SIZE_W-1:0] s);
      return (s > DIM) ? DIM : int'(s);
   endfunction

   // predictor: update the element stores or compute the dot product for a read
   function automatic void model_request(mm_request_type r);
      int                          n;
      bit                          outside;
      logic signed [31:0]          term;
      logic signed [PRODUCT_W-1:0] acc;
      dot_result_type              res;
      n = dim_in_use(size_now);
      outside = (int'(r.row) >= n) || (int'(r.col) >= n);
      acc = '0;
      if (r.kind == REQ_WRITE_A || r.kind == REQ_WRITE_B) begin
         if (!outside) begin
            if (r.kind == REQ_WRITE_A) a_elems[r.row * DIM + r.col] = r.value;
            else b_elems[r.row * DIM + r.col] = r.value;
         end
      end else if (r.kind == REQ_READ) begin
         if (!outside) begin
            for (int k = 0; k < n; k++) begin
               term = a_elems[r.row * DIM + k] * b_elems[k * DIM + r.col];
               acc = acc + term;
            end
         end
         res.product = acc;
         res.row = r.row;
         res.col = r.col;
         res.oor = outside;
         expected_products.push_back(res);
      end
   endfunction

   // queue one request and track which store entries become defined
   function automatic void queue_req(logic [REQ_W-1:0] kind, int row, int col,
                                     logic signed [VALUE_W-1:0] value);
      mm_request_type r;
      int             n;
      n = dim_in_use(size_now);
      r.kind = kind;
      r.row = row[COORD_W-1:0];
      r.col = col[COORD_W-1:0];
      r.value = value;
      pending_reqs.push_back(r);
      if (kind == REQ_READ) phase_count++;
      if ((kind == REQ_WRITE_A || kind == REQ_WRITE_B) && row < n && col < n) begin
         phase_count++;
         if (kind == REQ_WRITE_A) a_written[row * DIM + col] = 1'b1;
         else b_written[row * DIM + col] = 1'b1;
      end
   endfunction

   // a read in range first fills any row or column entry never written
   function automatic void queue_read(int row, int col);
      int n;
      n = dim_in_use(size_now);
      if (row < n && col < n) begin
         for (int k = 0; k < n; k++) begin
            if (!a_written[row * DIM + k])
               queue_req(REQ_WRITE_A, row, k, VALUE_W'($urandom));
            if (!b_written[k * DIM + col])
               queue_req(REQ_WRITE_B, k, col, VALUE_W'($urandom));
         end
      end
      queue_req(REQ_READ, row, col, VALUE_W'($urandom));
   endfunction

   // mostly in-range coordinates, some anywhere in the field
   function automatic int pick_coord();
      int n;
      n = dim_in_use(size_now);
      if (n > 0 && $urandom_range(0, 3) != 0) return $urandom_range(0, n - 1);
      return $urandom_range(0, DIM - 1);
   endfunction

   // wait until every request is taken and every product has come back
   task automatic wait_drain();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || start || expected_products.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_size(logic [SIZE_W-1:0] s);
      wait_drain();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= s;
      size_now = s;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // driver: one request on the ports until its transfer, random gaps between requests
   int             hold_off = 0;
   int             burst_left = 0;
   mm_request_type cur_req;
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         hold_off = 0;
      end else begin
         if (start && !busy) begin
            model_request(cur_req);
            if (burst_left > 0) begin
               burst_left--;
               hold_off = 0;
            end else if ($urandom_range(0, 15) == 0) begin
               burst_left = $urandom_range(8, 40);
               hold_off = 0;
            end else begin
               hold_off = $urandom_range(0, 7);
            end
         end
         if (!(start && busy)) begin
            if (hold_off > 0) begin
               hold_off--;
               start <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               cur_req = pending_reqs.pop_front();
               start <= 1'b1;
               req_type <= cur_req.kind;
               req_row <= cur_req.row;
               req_col <= cur_req.col;
               req_value <= cur_req.value;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each response transfer with the oldest predicted product
   always @(posedge clock) begin
      dot_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_products.size() == 0) begin
            $error("unexpected response: row %0d col %0d product %0d",
                   rsp_out_row, rsp_out_col, rsp_product);
            mismatches++;
         end else begin
            want = expected_products.pop_front();
            if (rsp_product !== want.product) begin
               $error("product: expected %0d, actual %0d", want.product, rsp_product);
               mismatches++;
            end
            if (rsp_out_row !== want.row) begin
               $error("out_row: expected %0d, actual %0d", want.row, rsp_out_row);
               mismatches++;
            end
            if (rsp_out_col !== want.col) begin
               $error("out_col: expected %0d, actual %0d", want.col, rsp_out_col);
               mismatches++;
            end
            if (rsp_out_of_range !== want.oor) begin
               $error("out_of_range: expected %0d, actual %0d", want.oor, rsp_out_of_range);
               mismatches++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      logic [SIZE_W-1:0] size_plan [10];
      int                pick;
      size_plan = '{5'd31, 5'd2, 5'd16, 5'd0, 5'd7, 5'd1, 5'd12, 5'd20, 5'd3, 5'd16};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // size after reset: largest positive and most negative sums
      for (int k = 0; k < DIM; k++) begin
         queue_req(REQ_WRITE_A, DIM - 1, k, VAL_MIN);
         queue_req(REQ_WRITE_B, k, DIM - 1, VAL_MIN);
         queue_req(REQ_WRITE_B, k, 0, VAL_MAX);
      end
      queue_read(DIM - 1, DIM - 1);
      queue_read(DIM - 1, 0);
      queue_req(REQ_UNUSED, 3, 4, VAL_MAX);
      queue_read(DIM - 1, DIM - 1);

      // empty matrices: everything out of range, writes dropped
      write_size(5'd0);
      queue_read(0, 0);
      queue_read(DIM - 1, DIM - 1);
      queue_req(REQ_WRITE_A, 0, 0, 16'sd5);
      queue_req(REQ_WRITE_B, 0, 0, 16'sd5);
      queue_req(REQ_UNUSED, 0, 0, '0);

      // single element, plus out-of-range reads and a dropped write
      write_size(5'd1);
      queue_req(REQ_WRITE_A, 0, 0, VAL_MAX);
      queue_req(REQ_WRITE_B, 0, 0, VAL_MAX);
      queue_read(0, 0);
      queue_read(0, 1);
      queue_read(1, 0);
      queue_req(REQ_WRITE_B, 5, 5, VAL_MIN);
      queue_read(0, 0);

      // random phases over a spread of sizes, including saturation and zero
      foreach (size_plan[p]) begin
         write_size(size_plan[p]);
         phase_count = 0;
         while (phase_count < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
               queue_req(REQ_WRITE_A, pick_coord(), pick_coord(), VALUE_W'($urandom));
            else if (pick < 55)
               queue_req(REQ_WRITE_B, pick_coord(), pick_coord(), VALUE_W'($urandom));
            else if (pick < 95)
               queue_read(pick_coord(), pick_coord());
            else
               queue_req(REQ_UNUSED, pick_coord(), pick_coord(), VALUE_W'($urandom));
         end
      end

      wait_drain();
      if (mismatches == 0 && expected_products.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
